FILE: rtl/dmets_pkg.sv
// Shared types, codes and helper functions for the dual motor encoder target supervisor.
package dmets_pkg;

   // Number of motors handled by the supervisor.
   localparam int MOTOR_COUNT = 2;

   // Drive code that means stop.
   localparam logic [7:0] STOP_CODE = 8'd128;
   localparam logic [7:0] REV_NEAREST_CODE = 8'd127;
   localparam logic [7:0] FWD_NEAREST_CODE = 8'd129;

   // Action codes of a request.
   localparam logic [2:0] ACT_TICK        = 3'd0;
   localparam logic [2:0] ACT_FREE_MOVE   = 3'd1;
   localparam logic [2:0] ACT_OFFSET_MOVE = 3'd2;
   localparam logic [2:0] ACT_PAIR_MOVE   = 3'd3;
   localparam logic [2:0] ACT_UNLIMIT     = 3'd4;
   localparam logic [2:0] ACT_ZERO_ENC    = 3'd5;

   // Motor selector code that addresses both motors.
   localparam logic [1:0] SEL_BOTH = 2'd2;

   typedef struct packed {
      logic [2:0]         action;
      logic [1:0]         motor_select;
      logic [7:0]         power_a;
      logic signed [31:0] offset_a;
      logic [7:0]         power_b;
      logic signed [31:0] offset_b;
      logic signed [31:0] encoder_0;
      logic signed [31:0] encoder_1;
      logic [7:0]         speed_0;
      logic [7:0]         speed_1;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] send_mask;
      logic [7:0] drive_0;
      logic [7:0] drive_1;
      logic       zero_request;
      logic       movement_done;
      logic       done_0;
      logic       done_1;
   } rsp_payload_type;

   // Command from the top level to one motor lane.
   typedef struct packed {
      logic               tick;
      logic               start;
      logic               bounded;
      logic               unlimit;
      logic [7:0]         code;
      logic signed [31:0] offset;
      logic signed [31:0] encoder;
      logic [7:0]         speed;
   } motor_cmd_type;

   // Status returned by one motor lane for the item in progress.
   typedef struct packed {
      logic       send;
      logic [7:0] code;
      logic       done;
      logic       stopped;
   } motor_status_type;

   // Maps a magnitude and a direction sign to a drive code.
   function automatic logic [7:0] map_code(input logic [7:0] mag,
                                           input logic signed [31:0] dir);
      logic [7:0] half;
      logic [7:0] code;
      half = {1'b0, mag[7:1]};
      if (mag == 8'd0 || dir == 32'sd0) begin
         code = STOP_CODE;
      end else if (!dir[31]) begin
         code = REV_NEAREST_CODE + half;
         if (code <= STOP_CODE) begin
            code = FWD_NEAREST_CODE;
         end
      end else begin
         code = STOP_CODE - half;
         if (code == STOP_CODE) begin
            code = REV_NEAREST_CODE;
         end
      end
      return code;
   endfunction

   // Adds two 32-bit signed values, saturating to the 32-bit range.
   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] sum;
      logic signed [31:0] res;
      sum = {a[31], a} + {b[31], b};
      if (sum[32] != sum[31]) begin
         res = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         res = sum[31:0];
      end
      return res;
   endfunction

endpackage

FILE: rtl/dmets_ifs.sv
// Valid/ready channel interfaces for the request and response sides.
interface dmets_req_if;
   import dmets_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface dmets_rsp_if;
   import dmets_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/dmets_motor.sv
// State and per-item update logic for one motor.
module dmets_motor (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  dmets_pkg::motor_cmd_type    cmd,
   output dmets_pkg::motor_status_type status
);
   import dmets_pkg::*;

   logic signed [31:0] pos_now_ff, pos_now_in;
   logic signed [31:0] pos_before_ff, pos_before_in;
   logic signed [31:0] pos_target_ff, pos_target_in;
   logic [7:0]         drive_now_ff, drive_now_in;
   logic [7:0]         drive_before_ff, drive_before_in;
   logic [7:0]         drive_target_ff, drive_target_in;
   logic               finished_ff, finished_in;
   logic               free_ff, free_in;
   logic               reached;
   logic               send;

   // Next state and drive request for the item in progress.
   always_comb begin
      pos_now_in      = pos_now_ff;
      pos_before_in   = pos_before_ff;
      pos_target_in   = pos_target_ff;
      drive_now_in    = drive_now_ff;
      drive_before_in = drive_before_ff;
      drive_target_in = drive_target_ff;
      finished_in     = finished_ff;
      free_in         = free_ff;
      reached         = 1'b0;
      send            = 1'b0;

      if (cmd.tick) begin
         pos_now_in   = cmd.encoder;
         drive_now_in = cmd.speed;
         if (!finished_ff) begin
            if (!free_ff) begin
               // A bounded motor finishes once it reaches or passes its target.
               reached = (pos_before_ff < pos_target_ff && cmd.encoder >= pos_target_ff) ||
                         (pos_before_ff > pos_target_ff && cmd.encoder <= pos_target_ff);
               if (reached) begin
                  finished_in     = 1'b1;
                  free_in         = 1'b1;
                  drive_target_in = STOP_CODE;
                  pos_target_in   = cmd.encoder;
               end
               send = (reached || drive_before_ff == cmd.speed) &&
                      drive_target_in != cmd.speed;
            end else begin
               send = cmd.speed != drive_target_ff;
            end
         end
      end else if (cmd.start) begin
         // Snapshot the current measurement and set up the new move.
         pos_before_in   = pos_now_ff;
         drive_before_in = drive_now_ff;
         drive_target_in = cmd.code;
         if (cmd.bounded) begin
            pos_target_in = sat_add(pos_now_ff, cmd.offset);
         end
         free_in     = !cmd.bounded;
         finished_in = 1'b0;
      end else if (cmd.unlimit) begin
         free_in = 1'b1;
      end
   end

   // Status for the response of this item.
   always_comb begin
      status.send    = send;
      status.code    = send ? drive_target_in : STOP_CODE;
      status.done    = finished_in;
      status.stopped = drive_now_in == STOP_CODE && drive_target_in == STOP_CODE;
   end

   // State registers, updated once per processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_now_ff      <= '0;
         pos_before_ff   <= '0;
         pos_target_ff   <= '0;
         drive_now_ff    <= STOP_CODE;
         drive_before_ff <= STOP_CODE;
         drive_target_ff <= STOP_CODE;
         finished_ff     <= 1'b1;
         free_ff         <= 1'b1;
      end else if (fire) begin
         pos_now_ff      <= pos_now_in;
         pos_before_ff   <= pos_before_in;
         pos_target_ff   <= pos_target_in;
         drive_now_ff    <= drive_now_in;
         drive_before_ff <= drive_before_in;
         drive_target_ff <= drive_target_in;
         finished_ff     <= finished_in;
         free_ff         <= free_in;
      end
   end

endmodule

FILE: rtl/dual_motor_encoder_target_supervisor.sv
// A request passes the input register and then the result register before its response can transfer.
// Throughput: one request per cycle while responses are taken; the state update logic is a single registered pass.
// The request side keeps accepting while a response waits, until both registers hold an item.
// Reset (synchronous, active high) empties both registers, stops both motors in their state,
// marks them finished and free-spinning, and clears any pending encoder-zero request.
module dual_motor_encoder_target_supervisor (
   input logic        clock,
   input logic        reset,
   dmets_req_if.sink   req_if,
   dmets_rsp_if.source rsp_if
);
   import dmets_pkg::*;

   logic                s1_valid_ff;
   req_payload_type     s1_data_ff;
   logic                out_valid_ff;
   rsp_payload_type     out_data_ff;
   rsp_payload_type     result;
   logic                zero_pending_ff, zero_pending_in;
   logic                advance;
   logic                fire;
   motor_cmd_type       cmd    [MOTOR_COUNT];
   motor_status_type    status [MOTOR_COUNT];

   // Handshake: the result register moves when empty or taken.
   assign advance      = !out_valid_ff || rsp_if.ready;
   assign fire         = s1_valid_ff && advance;
   assign req_if.ready = !s1_valid_ff || advance;
   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_data_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         s1_data_ff <= req_if.payload;
      end
   end

   // Per-motor command decode and motor lanes.
   for (genvar k = 0; k < MOTOR_COUNT; k++) begin : g_motor
      logic               hit;
      logic               pair_b;
      logic [7:0]         power;
      logic signed [31:0] offset;

      always_comb begin
         hit    = s1_data_ff.motor_select == 2'(k) || s1_data_ff.motor_select == SEL_BOTH;
         pair_b = s1_data_ff.action == ACT_PAIR_MOVE && k == 1;
         power  = pair_b ? s1_data_ff.power_b : s1_data_ff.power_a;
         offset = pair_b ? s1_data_ff.offset_b : s1_data_ff.offset_a;

         cmd[k].tick    = s1_data_ff.action == ACT_TICK;
         cmd[k].start   = (hit && (s1_data_ff.action inside {ACT_FREE_MOVE, ACT_OFFSET_MOVE})) ||
                          s1_data_ff.action == ACT_PAIR_MOVE;
         cmd[k].bounded = s1_data_ff.action != ACT_FREE_MOVE;
         cmd[k].unlimit = hit && s1_data_ff.action == ACT_UNLIMIT;
         cmd[k].code    = map_code(power, offset);
         cmd[k].offset  = offset;
         cmd[k].encoder = (k == 0) ? s1_data_ff.encoder_0 : s1_data_ff.encoder_1;
         cmd[k].speed   = (k == 0) ? s1_data_ff.speed_0 : s1_data_ff.speed_1;
      end

      dmets_motor u_motor (
         .clock  (clock),
         .reset  (reset),
         .fire   (fire),
         .cmd    (cmd[k]),
         .status (status[k])
      );
   end

   // Encoder-zero request: raised by its action, forwarded and cleared on the next tick.
   always_comb begin
      zero_pending_in = zero_pending_ff;
      if (s1_data_ff.action == ACT_TICK) begin
         zero_pending_in = 1'b0;
      end else if (s1_data_ff.action == ACT_ZERO_ENC) begin
         zero_pending_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_pending_ff <= 1'b0;
      end else if (fire) begin
         zero_pending_ff <= zero_pending_in;
      end
   end

   // Result assembly.
   always_comb begin
      result.send_mask     = {status[1].send, status[0].send};
      result.drive_0       = status[0].code;
      result.drive_1       = status[1].code;
      result.zero_request  = s1_data_ff.action == ACT_TICK && zero_pending_ff;
      result.movement_done = status[0].stopped && status[1].stopped;
      result.done_0        = status[0].done;
      result.done_1        = status[1].done;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff <= result;
      end
   end

endmodule

FILE: rtl/dmets_checker.sv
// Port-level assertions for the supervisor and the bind that attaches them.
module dmets_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input dmets_pkg::rsp_payload_type rsp_payload
);
   import dmets_pkg::*;

   // A stalled response holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // The response side is empty after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // A motor that is not addressed by the transfer shows the stop code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (!rsp_payload.send_mask[0] || !rsp_payload.send_mask[1]) |->
         (rsp_payload.send_mask[0] || rsp_payload.drive_0 == STOP_CODE) &&
         (rsp_payload.send_mask[1] || rsp_payload.drive_1 == STOP_CODE))
      else $error("unsent drive code is not stop");

   // A finished motor can only be sent the stop code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_payload.send_mask[0] && rsp_payload.done_0) ||
                    (rsp_payload.send_mask[1] && rsp_payload.done_1)) |->
         (!(rsp_payload.send_mask[0] && rsp_payload.done_0) ||
          rsp_payload.drive_0 == STOP_CODE) &&
         (!(rsp_payload.send_mask[1] && rsp_payload.done_1) ||
          rsp_payload.drive_1 == STOP_CODE))
      else $error("finished motor sent a moving code");

   // With all targets at stop, any code sent is the stop code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.movement_done |->
         (!rsp_payload.send_mask[0] || rsp_payload.drive_0 == STOP_CODE) &&
         (!rsp_payload.send_mask[1] || rsp_payload.drive_1 == STOP_CODE))
      else $error("moving code sent while movement is done");

endmodule

bind dual_motor_encoder_target_supervisor dmets_checker u_dmets_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);

FILE: test/tb_dual_motor_encoder_target_supervisor.sv
`timescale 1ns / 100ps
// Self-checking testbench for the dual motor encoder target supervisor.
module tb_dual_motor_encoder_target_supervisor;
   import dmets_pkg::*;

   // Action and selector codes that the package does not name.
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;
   localparam logic [1:0] SEL_MOTOR_0 = 2'd0;
   localparam logic [1:0] SEL_MOTOR_1 = 2'd1;
   localparam logic [1:0] SEL_NONE = 2'd3;

   localparam longint POS_MAX = 64'sd2147483647;
   localparam longint POS_MIN = -64'sd2147483648;
   localparam int NO_CODE = -1;
   localparam int STALL_LIMIT = 2000;
   localparam int PRESSURE_HOLD = 60;

   logic clock;
   logic reset;

   dmets_req_if req_chan ();
   dmets_rsp_if rsp_chan ();

   dual_motor_encoder_target_supervisor u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   // Mirror of the supervisor state, starting from its reset values.
   logic signed [31:0] meas_pos[MOTOR_COUNT] = '{32'sd0, 32'sd0};
   logic signed [31:0] start_pos[MOTOR_COUNT] = '{32'sd0, 32'sd0};
   logic signed [31:0] goal_pos[MOTOR_COUNT] = '{32'sd0, 32'sd0};
   logic [7:0] meas_code[MOTOR_COUNT] = '{STOP_CODE, STOP_CODE};
   logic [7:0] start_code[MOTOR_COUNT] = '{STOP_CODE, STOP_CODE};
   logic [7:0] goal_code[MOTOR_COUNT] = '{STOP_CODE, STOP_CODE};
   bit motor_finished[MOTOR_COUNT] = '{1'b1, 1'b1};
   bit motor_free[MOTOR_COUNT] = '{1'b1, 1'b1};
   bit zero_waiting = 1'b0;

   rsp_payload_type predicted_commands_q[$];
   int error_count = 0;
   int items_sent = 0;
   bit idling_on = 1'b1;
   int hold_request = 0;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Maps a magnitude and a direction sign to a drive code.
   function automatic logic [7:0] drive_code_for(input logic [7:0] mag,
                                                 input logic signed [31:0] dir);
      logic [8:0] c;
      if (mag == 8'd0 || dir == 32'sd0) begin
         return STOP_CODE;
      end
      if (dir > 32'sd0) begin
         c = 9'd127 + {2'b00, mag[7:1]};
         if (c <= 9'd128) begin
            c = 9'd129;
         end
      end else begin
         c = 9'd128 - {2'b00, mag[7:1]};
         if (c == 9'd128) begin
            c = 9'd127;
         end
      end
      return c[7:0];
   endfunction

   // Target position: base plus offset, clamped to the 32-bit range.
   function automatic logic signed [31:0] target_from(input logic signed [31:0] base,
                                                      input logic signed [31:0] off);
      longint s;
      s = longint'(base) + longint'(off);
      if (s > POS_MAX) s = POS_MAX;
      if (s < POS_MIN) s = POS_MIN;
      return s[31:0];
   endfunction

   function automatic void begin_move(input int k, input logic [7:0] code, input bit bounded,
                                      input logic signed [31:0] off);
      start_pos[k] = meas_pos[k];
      start_code[k] = meas_code[k];
      goal_code[k] = code;
      if (bounded) begin
         goal_pos[k] = target_from(meas_pos[k], off);
      end
      motor_free[k] = !bounded;
      motor_finished[k] = 1'b0;
   endfunction

   function automatic void stop_motor(input int k);
      motor_finished[k] = 1'b1;
      motor_free[k] = 1'b1;
      goal_code[k] = STOP_CODE;
      goal_pos[k] = meas_pos[k];
   endfunction

   // Advances the mirror by one request and returns the drive command it should give.
   function automatic rsp_payload_type supervise_step(input req_payload_type r);
      rsp_payload_type res;
      int ask[MOTOR_COUNT];
      logic [7:0] code;
      res = '0;
      res.drive_0 = STOP_CODE;
      res.drive_1 = STOP_CODE;
      ask = '{NO_CODE, NO_CODE};
      case (r.action)
         ACT_TICK: begin
            meas_pos[0] = r.encoder_0;
            meas_pos[1] = r.encoder_1;
            meas_code[0] = r.speed_0;
            meas_code[1] = r.speed_1;
            if (zero_waiting) begin
               zero_waiting = 1'b0;
               res.zero_request = 1'b1;
            end
            if (!(motor_finished[0] && motor_finished[1])) begin
               for (int k = 0; k < MOTOR_COUNT; k++) begin
                  if (!motor_finished[k] && !motor_free[k]) begin
                     // A bounded run stops once it reaches or passes its target.
                     if ((start_pos[k] < goal_pos[k] && meas_pos[k] >= goal_pos[k]) ||
                         (start_pos[k] > goal_pos[k] && meas_pos[k] <= goal_pos[k])) begin
                        stop_motor(k);
                        ask[k] = STOP_CODE;
                     end
                     if (start_code[k] == meas_code[k] && goal_code[k] != meas_code[k]) begin
                        ask[k] = goal_code[k];
                     end
                  end else if (!motor_finished[k] && meas_code[k] != goal_code[k]) begin
                     ask[k] = goal_code[k];
                  end
               end
               // Commands that would change nothing are dropped.
               for (int k = 0; k < MOTOR_COUNT; k++) begin
                  if (ask[k] == int'(meas_code[k])) begin
                     ask[k] = NO_CODE;
                  end
                  if (ask[k] != NO_CODE) begin
                     code = 8'(ask[k]);
                     res.send_mask[k] = 1'b1;
                     if (k == 0) res.drive_0 = code;
                     else res.drive_1 = code;
                  end
               end
            end
         end
         ACT_FREE_MOVE, ACT_OFFSET_MOVE: begin
            code = drive_code_for(r.power_a, r.offset_a);
            for (int k = 0; k < MOTOR_COUNT; k++) begin
               if (r.motor_select == k || r.motor_select == SEL_BOTH) begin
                  begin_move(k, code, r.action == ACT_OFFSET_MOVE, r.offset_a);
               end
            end
         end
         ACT_PAIR_MOVE: begin
            begin_move(0, drive_code_for(r.power_a, r.offset_a), 1'b1, r.offset_a);
            begin_move(1, drive_code_for(r.power_b, r.offset_b), 1'b1, r.offset_b);
         end
         ACT_UNLIMIT: begin
            for (int k = 0; k < MOTOR_COUNT; k++) begin
               if (r.motor_select == k || r.motor_select == SEL_BOTH) begin
                  motor_free[k] = 1'b1;
               end
            end
         end
         ACT_ZERO_ENC: begin
            zero_waiting = 1'b1;
         end
         default: begin
         end
      endcase
      res.movement_done = (meas_code[0] == STOP_CODE && meas_code[1] == STOP_CODE &&
                           goal_code[0] == STOP_CODE && goal_code[1] == STOP_CODE);
      res.done_0 = motor_finished[0];
      res.done_1 = motor_finished[1];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("MISMATCH at %0t ns: %s got %0d, predicted %0d", $time, what, got, want);
   endtask

   // Compares one response transfer with the oldest prediction.
   task automatic check_response(input rsp_payload_type got);
      rsp_payload_type want;
      if (predicted_commands_q.size() == 0) begin
         report_mismatch("response with nothing outstanding, send_mask", got.send_mask, 0);
      end else begin
         want = predicted_commands_q.pop_front();
         if (got.send_mask !== want.send_mask)
            report_mismatch("send_mask", got.send_mask, want.send_mask);
         if (got.drive_0 !== want.drive_0)
            report_mismatch("drive_0", got.drive_0, want.drive_0);
         if (got.drive_1 !== want.drive_1)
            report_mismatch("drive_1", got.drive_1, want.drive_1);
         if (got.zero_request !== want.zero_request)
            report_mismatch("zero_request", got.zero_request, want.zero_request);
         if (got.movement_done !== want.movement_done)
            report_mismatch("movement_done", got.movement_done, want.movement_done);
         if (got.done_0 !== want.done_0)
            report_mismatch("done_0", got.done_0, want.done_0);
         if (got.done_1 !== want.done_1)
            report_mismatch("done_1", got.done_1, want.done_1);
      end
   endtask

   // Offers one request, waits for its transfer and records the prediction.
   task automatic send_item(input req_payload_type item);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= item;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predicted_commands_q.push_back(supervise_step(item));
      items_sent++;
   endtask

   // Command request; the tick-only fields carry random data, which must be ignored.
   task automatic send_command(input logic [2:0] act, input logic [1:0] sel,
                               input logic [7:0] pa, input logic signed [31:0] oa,
                               input logic [7:0] pb, input logic signed [31:0] ob);
      req_payload_type item;
      item.action = act;
      item.motor_select = sel;
      item.power_a = pa;
      item.offset_a = oa;
      item.power_b = pb;
      item.offset_b = ob;
      item.encoder_0 = $urandom;
      item.encoder_1 = $urandom;
      item.speed_0 = 8'($urandom_range(0, 255));
      item.speed_1 = 8'($urandom_range(0, 255));
      send_item(item);
   endtask

   // Tick request; the command fields carry random data.
   task automatic send_tick(input logic signed [31:0] e0, input logic signed [31:0] e1,
                            input logic [7:0] s0, input logic [7:0] s1);
      req_payload_type item;
      item.action = ACT_TICK;
      item.motor_select = 2'($urandom_range(0, 3));
      item.power_a = 8'($urandom_range(0, 255));
      item.offset_a = $urandom;
      item.power_b = 8'($urandom_range(0, 255));
      item.offset_b = $urandom;
      item.encoder_0 = e0;
      item.encoder_1 = e1;
      item.speed_0 = s0;
      item.speed_1 = s1;
      send_item(item);
   endtask

   // Mostly small offsets so that runs finish; now and then the full range.
   function automatic logic signed [31:0] pick_offset();
      if ($urandom_range(0, 3) == 0) begin
         return $urandom;
      end
      return int'($urandom_range(0, 2000)) - 1000;
   endfunction

   // Plausible encoder reading for motor k, based on where it is and where it is heading.
   function automatic logic signed [31:0] plan_position(input int k);
      longint here;
      longint goal;
      longint p;
      here = meas_pos[k];
      goal = goal_pos[k];
      case ($urandom_range(0, 5))
         0: p = here;
         1: p = goal;
         2: p = here + (goal - here) / 2;
         3: begin
            if (goal >= longint'(start_pos[k])) p = goal + longint'($urandom_range(1, 20));
            else p = goal - longint'($urandom_range(1, 20));
         end
         4: p = here + longint'($urandom_range(0, 40)) - 20;
         default: p = longint'($signed($urandom));
      endcase
      if (p > POS_MAX) p = POS_MAX;
      if (p < POS_MIN) p = POS_MIN;
      return p[31:0];
   endfunction

   // Measured drive code: usually one the supervisor knows about, sometimes random.
   function automatic logic [7:0] plan_speed(input int k);
      case ($urandom_range(0, 5))
         0: return meas_code[k];
         1: return start_code[k];
         2, 3: return goal_code[k];
         4: return STOP_CODE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic test_directed_cases();
      // Tick straight after reset: both motors are finished, so nothing is sent.
      send_tick(32'sd0, 32'sd0, STOP_CODE, STOP_CODE);
      // Full forward magnitude on motor zero: issued, then stopped at the target.
      send_command(ACT_OFFSET_MOVE, SEL_MOTOR_0, 8'd255, 32'sd100, 8'd0, 32'sd0);
      send_tick(32'sd50, 32'sd0, STOP_CODE, STOP_CODE);
      send_tick(32'sd100, 32'sd0, 8'd254, STOP_CODE);
      // Reverse magnitude one on motor one, past its target at once: the stop is dropped.
      send_command(ACT_OFFSET_MOVE, SEL_MOTOR_1, 8'd1, -32'sd50, 8'd255, 32'sd0);
      send_tick(32'sd100, -32'sd60, STOP_CODE, STOP_CODE);
      // Forward magnitude two is raised to the nearest forward code, on both motors.
      send_command(ACT_FREE_MOVE, SEL_BOTH, 8'd2, 32'sd5, 8'd255, -32'sd1);
      send_tick(32'sd100, -32'sd60, STOP_CODE, STOP_CODE);
      send_tick(32'sd100, -32'sd60, FWD_NEAREST_CODE, FWD_NEAREST_CODE);
      // A zero direction stops free-spinning motors.
      send_command(ACT_FREE_MOVE, SEL_BOTH, 8'd200, 32'sd0, 8'd0, 32'sd0);
      send_tick(32'sd100, -32'sd60, FWD_NEAREST_CODE, FWD_NEAREST_CODE);
      // Zero magnitude, and a zero offset whose target never finishes.
      send_command(ACT_FREE_MOVE, SEL_MOTOR_0, 8'd0, -32'sd7, 8'd0, 32'sd0);
      send_command(ACT_OFFSET_MOVE, SEL_MOTOR_0, 8'd3, 32'sd0, 8'd0, 32'sd0);
      send_tick(32'sd5000, -32'sd60, 8'd7, STOP_CODE);
      // Selector three addresses no motor.
      send_command(ACT_OFFSET_MOVE, SEL_NONE, 8'd255, 32'sd100, 8'd0, 32'sd0);
      send_command(ACT_UNLIMIT, SEL_NONE, 8'd0, 32'sd0, 8'd0, 32'sd0);
      // Targets that saturate at both ends of the position range.
      send_tick(32'sh7fff_fff0, 32'sh8000_0010, STOP_CODE, STOP_CODE);
      send_command(ACT_PAIR_MOVE, SEL_MOTOR_0, 8'd255, 32'sh7fff_ffff, 8'd254,
                   32'sh8000_0000);
      send_tick(32'sh7fff_ffff, 32'sh8000_0000, 8'd254, 8'd1);
      // Removing the limits of a bounded run leaves it spinning freely.
      send_command(ACT_OFFSET_MOVE, SEL_MOTOR_1, 8'd128, -32'sd1000, 8'd0, 32'sd0);
      send_command(ACT_UNLIMIT, SEL_BOTH, 8'd0, 32'sd0, 8'd0, 32'sd0);
      send_tick(32'sd0, 32'sh8000_0000, STOP_CODE, STOP_CODE);
      // The encoder-zero request goes out on the next tick only.
      send_command(ACT_ZERO_ENC, SEL_MOTOR_0, 8'd0, 32'sd0, 8'd0, 32'sd0);
      send_tick(32'sd0, 32'sd0, STOP_CODE, 8'd64);
      send_tick(32'sd0, 32'sd0, STOP_CODE, 8'd64);
      // Unused action codes.
      send_command(ACT_SPARE_6, 2'($urandom_range(0, 3)), 8'd255, $urandom, 8'd255, $urandom);
      send_command(ACT_SPARE_7, 2'($urandom_range(0, 3)), 8'd0, $urandom, 8'd0, $urandom);
   endtask

   // Moves with random content followed by plausible ticks, with some noise mixed in.
   task automatic test_motion_sequences(input int count);
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0, 1, 2: send_command(ACT_OFFSET_MOVE, 2'($urandom_range(0, 3)),
                                  8'($urandom_range(0, 255)), pick_offset(),
                                  8'($urandom_range(0, 255)), $urandom);
            3, 4: send_command(ACT_PAIR_MOVE, 2'($urandom_range(0, 3)),
                               8'($urandom_range(0, 255)), pick_offset(),
                               8'($urandom_range(0, 255)), pick_offset());
            5: send_command(ACT_FREE_MOVE, 2'($urandom_range(0, 3)),
                            8'($urandom_range(0, 255)), pick_offset(),
                            8'($urandom_range(0, 255)), $urandom);
            6: send_command(ACT_UNLIMIT, 2'($urandom_range(0, 3)),
                            8'($urandom_range(0, 255)), $urandom,
                            8'($urandom_range(0, 255)), $urandom);
            7: send_command(ACT_ZERO_ENC, 2'($urandom_range(0, 3)),
                            8'($urandom_range(0, 255)), $urandom,
                            8'($urandom_range(0, 255)), $urandom);
            default: send_command(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                                  8'($urandom_range(0, 255)), $urandom,
                                  8'($urandom_range(0, 255)), $urandom);
         endcase
         repeat ($urandom_range(1, 8)) begin
            send_tick(plan_position(0), plan_position(1), plan_speed(0), plan_speed(1));
         end
      end
   endtask

   // The response side holds off for a long stretch while requests keep coming.
   task automatic test_backpressure();
      bit saved_idling;
      saved_idling = idling_on;
      idling_on = 1'b0;
      hold_request = PRESSURE_HOLD;
      send_command(ACT_PAIR_MOVE, SEL_BOTH, 8'd180, 32'sd300, 8'd90, -32'sd300);
      repeat (15) begin
         send_tick(plan_position(0), plan_position(1), plan_speed(0), plan_speed(1));
      end
      idling_on = saved_idling;
   endtask

   // Response side: checks each transfer and drives ready with random stalls.
   initial begin : response_side
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            check_response(rsp_chan.payload);
         end
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 5);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid & req_chan.ready) === 1'b1 ||
             (rsp_chan.valid & rsp_chan.ready) === 1'b1) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("tb_dual_motor_encoder_target_supervisor failed");
      $finish;
   end

   // Main sequence.
   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_motion_sequences(240);
      test_backpressure();
      // Last part of the run with no idling on either side.
      idling_on = 1'b0;
      test_motion_sequences(120);

      req_chan.valid <= 1'b0;
      while (predicted_commands_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_dual_motor_encoder_target_supervisor passed");
      end else begin
         $display("tb_dual_motor_encoder_target_supervisor failed");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/dmets_pkg.sv
rtl/dmets_ifs.sv
rtl/dmets_motor.sv
rtl/dual_motor_encoder_target_supervisor.sv
rtl/dmets_checker.sv
test/tb_dual_motor_encoder_target_supervisor.sv
